>>> sv/wdm_pkg.sv
// ----------------------------------------------------------------------------
// wdm_pkg: shared types, constants and table math for the waveshaper
// Register and mode codes, reset values, and the elaboration-time series
// math that fills the sine and tanh lookup tables.
// ----------------------------------------------------------------------------
package wdm_pkg;

  // Default sizes
  localparam int SAMPLE_BITS_DEF = 16;
  localparam int TABLE_DEPTH_DEF = 1024;

  // Configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  // Table entries are Q1.15 with one spare bit, since sine can round to +1.0
  localparam int ROM_W = 17;

  // Register limits and reset values
  localparam logic [15:0] GAIN_MAX     = 16'd40960;  // 2.5 in Q2.14
  localparam logic [15:0] MIX_ONE      = 16'd32768;  // 1.0 in Q1.15
  localparam logic [15:0] THR_RESET    = 16'h7fff;
  localparam logic [15:0] GAIN_RESET   = 16'd16384;
  localparam logic [15:0] MIX_RESET    = 16'd32768;

  typedef enum logic [1:0] {
    MODE_CLIP = 2'd0,
    MODE_SINE = 2'd1,
    MODE_TANH = 2'd2,
    MODE_CUBE = 2'd3
  } shape_mode_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SHAPE_MODE     = 2'd0,
    REG_CLIP_THRESHOLD = 2'd1,
    REG_DRIVE_GAIN     = 2'd2,
    REG_WET_MIX        = 2'd3
  } cfg_reg_t;

  typedef enum logic {
    TRIG_SIN  = 1'b0,
    TRIG_TANH = 1'b1
  } trig_kind_t;

  // 1.0 in the 24-bit fraction used by the series
  localparam longint ONE24 = 64'sd1 <<< 24;

  // Quotient truncated toward zero, by shift and subtract
  function automatic longint div_trunc(longint num, longint den);
    longint a;
    longint b;
    longint q;
    logic   neg;
    neg = (num < 0) != (den < 0);
    a   = (num < 0) ? -num : num;
    b   = (den < 0) ? -den : den;
    q   = 0;
    for (int k = 62; k >= 0; k--) begin
      if ((a >>> k) >= b) begin
        a = a - (b <<< k);
        q = q | (64'sd1 <<< k);
      end
    end
    return neg ? -q : q;
  endfunction

  // Taylor series of sine, truncating Q.24 arithmetic
  function automatic longint sin24(longint t);
    longint term;
    longint sum;
    term = t;
    sum  = t;
    for (int n = 1; n <= 14; n++) begin
      term = div_trunc(-(term * t / ONE24), longint'(2 * n));
      term = div_trunc(term * t / ONE24, longint'(2 * n + 1));
      sum  = sum + term;
    end
    return sum;
  endfunction

  // tanh(t) = (1 - e^-2|t|) / (1 + e^-2|t|), e^-|t|/2 from its series
  function automatic longint tanh24(longint t);
    longint u;
    longint v;
    longint term;
    longint e;
    longint e2;
    longint e4;
    longint r;
    u    = (t < 0) ? -t : t;
    v    = u / 2;
    term = ONE24;
    e    = ONE24;
    for (int n = 1; n <= 20; n++) begin
      term = div_trunc(-(term * v / ONE24), longint'(n));
      e    = e + term;
    end
    e2 = e * e / ONE24;
    e4 = e2 * e2 / ONE24;
    r  = div_trunc((ONE24 - e4) * ONE24, ONE24 + e4);
    return (t < 0) ? -r : r;
  endfunction

  // Table entry: f at the center of bin idx over [-4, 4), rounded to Q1.15.
  // Only evaluated at elaboration.
  function automatic logic signed [ROM_W-1:0] trig_entry(trig_kind_t kind, int idx,
                                                         int depth);
    longint t;
    longint f;
    t = -(64'sd1 <<< 26) +
        div_trunc((2 * longint'(idx) + 1) * (64'sd1 <<< 26), longint'(depth));
    if (kind == TRIG_SIN) begin
      f = sin24(t);
    end else begin
      f = tanh24(t);
    end
    return ROM_W'((f + 64'sd256) >>> 9);
  endfunction

endpackage

>>> sv/wdm_in_if.sv
// ----------------------------------------------------------------------------
// wdm_in_if: input sample channel
// Valid/ready channel carrying one signed sample and its end-of-block mark.
// ----------------------------------------------------------------------------
interface wdm_in_if #(
  parameter int SAMPLE_BITS = wdm_pkg::SAMPLE_BITS_DEF
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample_in;
  logic                          last_in;

  modport source (output valid, sample_in, last_in, input ready);
  modport sink   (input valid, sample_in, last_in, output ready);
endinterface

>>> sv/wdm_out_if.sv
// ----------------------------------------------------------------------------
// wdm_out_if: output sample channel
// Valid/ready channel carrying one processed sample and its end-of-block mark.
// ----------------------------------------------------------------------------
interface wdm_out_if #(
  parameter int SAMPLE_BITS = wdm_pkg::SAMPLE_BITS_DEF
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample_out;
  logic                          last_out;

  modport source (output valid, sample_out, last_out, input ready);
  modport sink   (input valid, sample_out, last_out, output ready);
endinterface

>>> sv/wdm_rom.sv
// ----------------------------------------------------------------------------
// wdm_rom: sine / tanh lookup table
// Constant table filled at elaboration, one read per cycle while en is high, registered data.
// ----------------------------------------------------------------------------
module wdm_rom #(
  parameter int                  DEPTH = wdm_pkg::TABLE_DEPTH_DEF,
  parameter wdm_pkg::trig_kind_t KIND  = wdm_pkg::TRIG_SIN,
  localparam int                 AW    = $clog2(DEPTH)
) (
  input  logic                             clk,
  input  logic                             en,
  input  logic [AW-1:0]                    addr,
  output logic signed [wdm_pkg::ROM_W-1:0] data
);
  import wdm_pkg::*;

  logic signed [ROM_W-1:0] tab [DEPTH];

  // Table contents
  for (genvar i = 0; i < DEPTH; i++) begin : g_tab
    localparam logic signed [ROM_W-1:0] ENTRY = trig_entry(KIND, i, DEPTH);
    assign tab[i] = ENTRY;
  end

  // Registered read, held while the pipeline stalls
  always_ff @(posedge clk) begin
    if (en) begin
      data <= tab[addr];
    end
  end

endmodule

>>> sv/waveshaper_distortion_mix_unit.sv
// ----------------------------------------------------------------------------
// waveshaper_distortion_mix_unit: waveshaping distortion with dry/wet blend
// Clip, sine, tanh or cube shaper on a Q1.15 sample, blended with the dry
// sample, rounded and saturated.
// ----------------------------------------------------------------------------
// Usage:
//   din carries one request per sample (sample_in, last_in); dout returns
//   exactly one sample per request, in order, with last_out copied through.
//   Registers are written through cfg_wr_en / cfg_index / cfg_wdata, only while no
//   sample is in flight (the user's duty; the block does not enforce it); drive and mix values above range clamp.
// Timing:
//   Six register stages; a sample accepted at one edge enters stage 1 at that
//   edge and moves on through stages 2 to 6 to dout.
//   One sample per clock is sustained while dout.ready stays high; the depth is
//   set by the cube path, three chained multiplies, each followed by a register,
//   plus the blend multiply and the final add.
// Reset:
//   rst clears every stage valid bit and restores the register defaults
//   (clip mode, threshold 32767, drive 1.0, fully wet). din.ready is low
//   while rst is high.
// Stall:
//   A result held on dout stays put. Upstream stages keep moving into any
//   empty slot, so din.ready only drops when all six stages are full.
// ----------------------------------------------------------------------------
module waveshaper_distortion_mix_unit #(
  parameter int SAMPLE_BITS = wdm_pkg::SAMPLE_BITS_DEF,
  parameter int TABLE_DEPTH = wdm_pkg::TABLE_DEPTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_wr_en,
  input  logic [wdm_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [wdm_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  wdm_in_if.sink                          din,
  wdm_out_if.source                       dout
);
  import wdm_pkg::*;

  localparam int FRAC    = SAMPLE_BITS - 1;
  localparam int AW      = $clog2(TABLE_DEPTH);
  localparam int X_W     = 32;   // sample with 30 fraction bits
  localparam int GP_W    = 49;   // X_W x 17-bit gain or mix
  localparam int SQ_W    = 64;   // X_W x X_W
  localparam int SH_W    = 35;   // shaped value, 30 fraction bits
  localparam int DRY_W   = 49;
  localparam int WET_W   = 52;
  localparam int ACC_W   = 53;
  localparam int OUT_SH  = 45 - FRAC;
  localparam int CMP_W   = SAMPLE_BITS + 16;
  localparam int IDXP_W  = 17 + $clog2(TABLE_DEPTH + 1);

  localparam logic signed [SQ_W-1:0]  RND_SQ  = SQ_W'(64'sd1 <<< 29);
  localparam logic signed [GP_W-1:0]  RND_GP  = GP_W'(64'sd1 <<< 13);
  localparam logic signed [ACC_W-1:0] RND_OUT = ACC_W'(64'sd1 <<< (OUT_SH - 1));
  localparam logic signed [ACC_W-1:0] Y_MAX   = ACC_W'((64'sd1 <<< FRAC) - 64'sd1);
  localparam logic signed [ACC_W-1:0] Y_MIN   = ACC_W'(-(64'sd1 <<< FRAC));

  // --------------------------------------------------------------------------
  // Configuration registers (drive and mix clamp on write)
  // --------------------------------------------------------------------------
  shape_mode_t        mode;
  logic signed [15:0] thr;
  logic [15:0]        gain;
  logic [15:0]        mix;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= MODE_CLIP;
      thr  <= signed'(THR_RESET);
      gain <= GAIN_RESET;
      mix  <= MIX_RESET;
    end else if (cfg_wr_en) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_SHAPE_MODE:     mode <= shape_mode_t'(cfg_wdata[1:0]);
        REG_CLIP_THRESHOLD: thr  <= signed'(cfg_wdata);
        REG_DRIVE_GAIN:     gain <= (cfg_wdata > GAIN_MAX) ? GAIN_MAX : cfg_wdata;
        REG_WET_MIX:        mix  <= (cfg_wdata > MIX_ONE) ? MIX_ONE : cfg_wdata;
      endcase
    end
  end

  logic signed [16:0]    gain_s;
  logic signed [16:0]    mix_s;
  logic signed [16:0]    dry_s;
  logic signed [X_W-1:0] thr30;

  assign gain_s = signed'({1'b0, gain});
  assign mix_s  = signed'({1'b0, mix});
  assign dry_s  = signed'({1'b0, MIX_ONE} - {1'b0, mix});
  assign thr30  = {thr[15], thr, 15'd0};

  // --------------------------------------------------------------------------
  // Handshake: each stage moves when it is empty or the next one moves
  // --------------------------------------------------------------------------
  logic [6:1] vld;
  logic [6:1] adv;

  always_comb begin
    adv[6] = ~vld[6] | dout.ready;
    for (int k = 5; k >= 1; k--) begin
      adv[k] = ~vld[k] | adv[k+1];
    end
  end

  assign din.ready = adv[1] & ~rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (adv[1]) begin
        vld[1] <= din.valid;
      end
      for (int k = 2; k <= 6; k++) begin
        if (adv[k]) begin
          vld[k] <= vld[k-1];
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stage 1: rescale to 30 fraction bits, threshold compare, drive product
  // --------------------------------------------------------------------------
  logic signed [X_W-1:0]   x30_in;
  logic signed [CMP_W-1:0] cmp_x;
  logic signed [CMP_W-1:0] cmp_t;
  logic signed [GP_W-1:0]  xg_in;

  if (FRAC <= 30) begin : g_x30_shl
    assign x30_in = X_W'(din.sample_in) <<< (30 - FRAC);
  end else begin : g_x30_rnd
    logic signed [X_W:0] x_rnd;
    assign x_rnd  = (X_W + 1)'(din.sample_in) + (X_W + 1)'(1);
    assign x30_in = x_rnd[X_W:1];
  end

  assign cmp_x = CMP_W'(din.sample_in) <<< 15;
  assign cmp_t = CMP_W'(thr) <<< FRAC;
  assign xg_in = GP_W'(x30_in) * GP_W'(gain_s);

  logic signed [X_W-1:0]  s1_x30;
  logic signed [GP_W-1:0] s1_xg;
  logic                   s1_lt;
  logic                   s1_last;

  always_ff @(posedge clk) begin
    if (adv[1]) begin
      s1_x30  <= x30_in;
      s1_xg   <= xg_in;
      s1_lt   <= cmp_x < cmp_t;
      s1_last <= din.last_in;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 2: clip product, square, table lookup
  // --------------------------------------------------------------------------
  logic signed [X_W-1:0]  clip_sel;
  logic signed [GP_W-1:0] clip_prod_c;
  logic signed [SQ_W-1:0] sq_c;
  logic [16:0]            q_off;
  logic [IDXP_W-1:0]      idx_prod;
  logic [AW-1:0]          rom_addr;
  logic signed [ROM_W-1:0] sin_d;
  logic signed [ROM_W-1:0] tanh_d;

  assign clip_sel    = s1_lt ? s1_x30 : thr30;
  assign clip_prod_c = GP_W'(clip_sel) * GP_W'(gain_s);
  assign sq_c        = SQ_W'(s1_x30) * SQ_W'(s1_x30);

  // Q3.13 product offset to unsigned; the clamped drive keeps it in range
  assign q_off    = s1_xg[47:31] + 17'd32768;
  assign idx_prod = IDXP_W'(q_off) * IDXP_W'(TABLE_DEPTH);
  assign rom_addr = idx_prod[16 +: AW];

  wdm_rom #(.DEPTH(TABLE_DEPTH), .KIND(TRIG_SIN)) u_sin_rom (
    .clk  (clk),
    .en   (adv[2]),
    .addr (rom_addr),
    .data (sin_d)
  );

  wdm_rom #(.DEPTH(TABLE_DEPTH), .KIND(TRIG_TANH)) u_tanh_rom (
    .clk  (clk),
    .en   (adv[2]),
    .addr (rom_addr),
    .data (tanh_d)
  );

  logic signed [X_W-1:0]  s2_x30;
  logic signed [GP_W-1:0] s2_clip_prod;
  logic signed [SQ_W-1:0] s2_sq;
  logic                   s2_last;

  always_ff @(posedge clk) begin
    if (adv[2]) begin
      s2_x30       <= s1_x30;
      s2_clip_prod <= clip_prod_c;
      s2_sq        <= sq_c;
      s2_last      <= s1_last;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 3: round square, cube product, round clip, pick table
  // --------------------------------------------------------------------------
  logic signed [SQ_W-1:0]  sq_rnd;
  logic signed [SQ_W-1:0]  cube2_c;
  logic signed [GP_W-1:0]  clip_rnd;
  logic signed [ROM_W-1:0] trig_c;

  assign sq_rnd   = s2_sq + RND_SQ;
  assign cube2_c  = SQ_W'(sq_rnd[61:30]) * SQ_W'(s2_x30);
  assign clip_rnd = s2_clip_prod + RND_GP;
  assign trig_c   = (mode == MODE_SINE) ? sin_d : tanh_d;

  logic signed [X_W-1:0]   s3_x30;
  logic signed [SQ_W-1:0]  s3_cube2;
  logic signed [SH_W-1:0]  s3_clip;
  logic signed [ROM_W-1:0] s3_trig;
  logic                    s3_last;

  always_ff @(posedge clk) begin
    if (adv[3]) begin
      s3_x30   <= s2_x30;
      s3_cube2 <= cube2_c;
      s3_clip  <= clip_rnd[48:14];
      s3_trig  <= trig_c;
      s3_last  <= s2_last;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 4: round cube, apply drive
  // --------------------------------------------------------------------------
  logic signed [SQ_W-1:0] cube2_rnd;
  logic signed [GP_W-1:0] cube3_c;

  // rounded cube can be negative; keep its sign into the drive product
  assign cube2_rnd = s3_cube2 + RND_SQ;
  assign cube3_c   = GP_W'(signed'(cube2_rnd[61:30])) * GP_W'(gain_s);

  logic signed [X_W-1:0]   s4_x30;
  logic signed [GP_W-1:0]  s4_cube3;
  logic signed [SH_W-1:0]  s4_clip;
  logic signed [ROM_W-1:0] s4_trig;
  logic                    s4_last;

  always_ff @(posedge clk) begin
    if (adv[4]) begin
      s4_x30   <= s3_x30;
      s4_cube3 <= cube3_c;
      s4_clip  <= s3_clip;
      s4_trig  <= s3_trig;
      s4_last  <= s3_last;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 5: select shaper, dry and wet products
  // --------------------------------------------------------------------------
  logic signed [GP_W-1:0]  cube3_rnd;
  logic signed [SH_W-1:0]  shaped;
  logic signed [DRY_W-1:0] dry_c;
  logic signed [WET_W-1:0] wet_c;

  assign cube3_rnd = s4_cube3 + RND_GP;

  always_comb begin
    case (mode) inside
      MODE_CLIP:            shaped = s4_clip;
      MODE_SINE, MODE_TANH: shaped = SH_W'(s4_trig) <<< 15;
      MODE_CUBE:            shaped = cube3_rnd[48:14];
    endcase
  end

  assign dry_c = DRY_W'(s4_x30) * DRY_W'(dry_s);
  assign wet_c = WET_W'(shaped) * WET_W'(mix_s);

  logic signed [DRY_W-1:0] s5_dry;
  logic signed [WET_W-1:0] s5_wet;
  logic                    s5_last;

  always_ff @(posedge clk) begin
    if (adv[5]) begin
      s5_dry  <= dry_c;
      s5_wet  <= wet_c;
      s5_last <= s4_last;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 6: blend, round half up, saturate; output register
  // --------------------------------------------------------------------------
  logic signed [ACC_W-1:0]       acc;
  logic signed [ACC_W-1:0]       y_full;
  logic signed [SAMPLE_BITS-1:0] y_sat;

  assign acc    = ACC_W'(s5_dry) + ACC_W'(s5_wet) + RND_OUT;
  assign y_full = acc >>> OUT_SH;

  always_comb begin
    if (y_full > Y_MAX) begin
      y_sat = Y_MAX[SAMPLE_BITS-1:0];
    end else if (y_full < Y_MIN) begin
      y_sat = Y_MIN[SAMPLE_BITS-1:0];
    end else begin
      y_sat = y_full[SAMPLE_BITS-1:0];
    end
  end

  logic signed [SAMPLE_BITS-1:0] s6_y;
  logic                          s6_last;

  always_ff @(posedge clk) begin
    if (adv[6]) begin
      s6_y    <= y_sat;
      s6_last <= s5_last;
    end
  end

  assign dout.valid      = vld[6];
  assign dout.sample_out = s6_y;
  assign dout.last_out   = s6_last;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  // An accepted request always lands in stage 1
  a_accept_lands: assert property (@(posedge clk) disable iff (rst)
    din.valid && din.ready |=> vld[1])
    else $error("accepted request missing from stage 1");

  // Any empty stage lets the input side take a request
  a_bubble_ready: assert property (@(posedge clk) disable iff (rst)
    !(&vld) |-> din.ready)
    else $error("input stalled with an empty pipeline stage");

  // A stalled result keeps its slot and its value
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    vld[6] && !dout.ready |=> vld[6] && $stable(s6_y) && $stable(s6_last))
    else $error("stalled output changed or dropped");

endmodule

>>> verif/waveshaper_distortion_mix_unit_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// waveshaper_distortion_mix_unit_test: self-checking bench for the waveshaper
// Drives sample requests through the valid/ready channels and reprograms the
// four registers between bursts. Each accepted request is predicted by an
// independent fixed-point model of the clip, sine, tanh and cube shapers and
// the dry/wet blend, and the prediction is compared in order with the output.
// ----------------------------------------------------------------------------
module waveshaper_distortion_mix_unit_test;
  import wdm_pkg::*;

  localparam int SAMPLE_BITS = SAMPLE_BITS_DEF;
  localparam int TABLE_DEPTH = TABLE_DEPTH_DEF;
  localparam int HOLD_CYCLES = 250;   // long output stall for back-pressure
  localparam int QUIET_LIMIT = 2000;  // cycles without any handshake
  localparam int DRAIN_CYCLES = 20;   // pipeline is six stages deep

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;

  typedef struct {
    sample_t sample;
    logic    last;
  } mix_result_t;

  // Fixed-point predictor plus ordered store of expected output samples
  class mix_scoreboard;
    shape_mode_t   mode;
    logic signed [15:0] threshold;
    logic [15:0]   drive;
    logic [15:0]   wet;
    longint        sine_tab[TABLE_DEPTH];
    longint        tanh_tab[TABLE_DEPTH];
    mix_result_t   awaiting[$];
    int            mismatches;
    int            checked;
    int            per_mode[4];

    function new();
      longint t;
      mode       = MODE_CLIP;
      threshold  = THR_RESET;
      drive      = GAIN_RESET;
      wet        = MIX_RESET;
      mismatches = 0;
      checked    = 0;
      foreach (per_mode[i]) per_mode[i] = 0;
      // bin centers over [-4, 4) in Q.24, entries rounded to Q1.15
      for (int i = 0; i < TABLE_DEPTH; i++) begin
        t = -(64'sd1 <<< 26) + (longint'(2 * i + 1) * (64'sd1 <<< 26)) / TABLE_DEPTH;
        sine_tab[i] = round_shift(sine_q24(t), 9);
        tanh_tab[i] = round_shift(tanh_q24(t), 9);
      end
    endfunction

    // floor((v + half) / 2^k)
    function longint round_shift(longint v, int k);
      return (v + (64'sd1 <<< (k - 1))) >>> k;
    endfunction

    // Taylor series with truncating Q.24 steps
    function longint sine_q24(longint t);
      longint term;
      longint acc;
      term = t;
      acc  = t;
      for (int n = 1; n <= 14; n++) begin
        term = -(term * t / (64'sd1 <<< 24)) / longint'(2 * n);
        term = (term * t / (64'sd1 <<< 24)) / longint'(2 * n + 1);
        acc  = acc + term;
      end
      return acc;
    endfunction

    // e^(-|t|/2) by series, raised to the 4th, then (1 - e4) / (1 + e4)
    function longint tanh_q24(longint t);
      longint one;
      longint half_mag;
      longint term;
      longint ex;
      longint ex2;
      longint ex4;
      longint r;
      one      = 64'sd1 <<< 24;
      half_mag = ((t < 0) ? -t : t) / 2;
      term     = one;
      ex       = one;
      for (int n = 1; n <= 20; n++) begin
        term = -(term * half_mag / one) / longint'(n);
        ex   = ex + term;
      end
      ex2 = ex * ex / one;
      ex4 = ex2 * ex2 / one;
      r   = (one - ex4) * one / (one + ex4);
      return (t < 0) ? -r : r;
    endfunction

    function void set_reg(cfg_reg_t idx, logic [15:0] data);
      case (idx)
        REG_SHAPE_MODE:     mode = shape_mode_t'(data[1:0]);
        REG_CLIP_THRESHOLD: threshold = data;
        REG_DRIVE_GAIN:     drive = data;
        REG_WET_MIX:        wet = data;
        default: ;
      endcase
    endfunction

    function int pending();
      return awaiting.size();
    endfunction

    // Work out the output sample for one accepted request
    function void note_request(sample_t s, logic l);
      longint x;
      longint x30;
      longint g;
      longint m;
      longint shaped;
      longint p;
      longint idx;
      longint y;
      mix_result_t res;
      x   = longint'(s);
      x30 = x * 32768;
      g   = (drive > GAIN_MAX) ? longint'(GAIN_MAX) : longint'(drive);
      m   = (wet > MIX_ONE) ? longint'(MIX_ONE) : longint'(wet);
      case (mode)
        MODE_CLIP: begin
          if (x < longint'(threshold)) begin
            shaped = round_shift(x30 * g, 14);
          end else begin
            shaped = round_shift(longint'(threshold) * 32768 * g, 14);
          end
        end
        MODE_SINE, MODE_TANH: begin
          // top bits of the driven sample in Q3.13 pick the table bin
          p   = (x30 * g) >>> 31;
          idx = ((p + 32768) * TABLE_DEPTH) / 65536;
          if (idx < 0) idx = 0;
          if (idx > TABLE_DEPTH - 1) idx = TABLE_DEPTH - 1;
          shaped = ((mode == MODE_SINE) ? sine_tab[idx] : tanh_tab[idx]) * 32768;
        end
        default: begin
          p      = round_shift(x30 * x30, 30);
          p      = round_shift(p * x30, 30);
          shaped = round_shift(p * g, 14);
        end
      endcase
      y = round_shift(x30 * (32768 - m) + shaped * m, 30);
      if (y > 32767) y = 32767;
      if (y < -32768) y = -32768;
      res.sample = sample_t'(y);
      res.last   = l;
      awaiting.push_back(res);
      per_mode[mode]++;
    endfunction

    function void check_result(sample_t s, logic l);
      mix_result_t want;
      if (awaiting.size() == 0) begin
        $display("%0t: unexpected result sample_out=%0d last_out=%0b", $time, s, l);
        mismatches++;
        return;
      end
      want = awaiting.pop_front();
      checked++;
      if (s !== want.sample) begin
        $display("%0t: sample_out mismatch: expected %0d, actual %0d",
                 $time, want.sample, s);
        mismatches++;
      end
      if (l !== want.last) begin
        $display("%0t: last_out mismatch: expected %0b, actual %0b",
                 $time, want.last, l);
        mismatches++;
      end
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  cfg_wr_en;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  wdm_in_if  #(.SAMPLE_BITS(SAMPLE_BITS)) in_ch ();
  wdm_out_if #(.SAMPLE_BITS(SAMPLE_BITS)) out_ch ();

  waveshaper_distortion_mix_unit #(
    .SAMPLE_BITS(SAMPLE_BITS),
    .TABLE_DEPTH(TABLE_DEPTH)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_wr_en(cfg_wr_en),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata),
    .din      (in_ch),
    .dout     (out_ch)
  );

  mix_scoreboard sb;
  int            send_idle_pct = 0;
  int            stall_pct = 0;
  int            holds_asked = 0;
  int            holds_done = 0;
  int            reg_writes = 0;
  sample_t       plan[$];

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Known values on every input from time zero
  initial begin
    rst             = 1'b1;
    cfg_wr_en       <= 1'b0;
    cfg_index       <= REG_SHAPE_MODE;
    cfg_wdata       <= '0;
    in_ch.valid     <= 1'b0;
    in_ch.sample_in <= '0;
    in_ch.last_in   <= 1'b0;
  end

  // Output side: random stalls, plus an occasional long hold
  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (holds_done != holds_asked) begin
        holds_done++;
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        out_ch.ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  // Sample both channels at the edge
  always @(posedge clk) begin
    if (!rst) begin
      if (in_ch.valid && in_ch.ready) sb.note_request(in_ch.sample_in, in_ch.last_in);
      if (out_ch.valid && out_ch.ready) sb.check_result(out_ch.sample_out, out_ch.last_out);
    end
  end

  // Watchdog: too long with no handshake on either side
  initial begin
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) quiet = 0;
      else quiet++;
    end
    $display("%0t: no handshake for %0d cycles", $time, QUIET_LIMIT);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // One register write per cycle; enable stays up through a group
  task automatic write_reg(cfg_reg_t idx, logic [15:0] data);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    sb.set_reg(idx, data);
    reg_writes++;
    @(posedge clk);
  endtask

  task automatic apply_settings(logic [15:0] mode_word, logic [15:0] thr,
                                logic [15:0] gain, logic [15:0] mix);
    write_reg(REG_SHAPE_MODE, mode_word);
    write_reg(REG_CLIP_THRESHOLD, thr);
    write_reg(REG_DRIVE_GAIN, gain);
    write_reg(REG_WET_MIX, mix);
    cfg_wr_en <= 1'b0;
  endtask

  // Offer one request and hold it until taken
  task automatic offer(sample_t s, logic l);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.sample_in <= s;
    in_ch.last_in   <= l;
    @(posedge clk);
    while (in_ch.ready !== 1'b1) @(posedge clk);
  endtask

  // Stop offering and wait for every expected sample
  task automatic close_burst();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  task automatic run_plan();
    foreach (plan[i]) offer(plan[i], i == plan.size() - 1);
    close_burst();
  endtask

  function automatic sample_t random_sample();
    case ($urandom_range(7))
      0:       return 16'sh8000;
      1:       return 16'sh7fff;
      2:       return sample_t'(int'($urandom_range(1023)) - 512);
      default: return sample_t'($urandom);
    endcase
  endfunction

  function automatic logic [15:0] pick_drive();
    case ($urandom_range(3))
      0:       return 16'd0;
      1:       return GAIN_MAX;
      2:       return 16'($urandom_range(65535, 40961));
      default: return 16'($urandom_range(40960));
    endcase
  endfunction

  function automatic logic [15:0] pick_mix();
    case ($urandom_range(3))
      0:       return 16'd0;
      1:       return MIX_ONE;
      2:       return 16'($urandom_range(65535, 32769));
      default: return 16'($urandom_range(32768));
    endcase
  endfunction

  function automatic logic [15:0] pick_threshold();
    case ($urandom_range(2))
      0:       return 16'h8000;
      1:       return 16'h7fff;
      default: return 16'($urandom);
    endcase
  endfunction

  initial begin
    logic [15:0] mode_word;
    sb = new();
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Reset settings: clip at full scale, sample equal to threshold clips
    plan = '{16'sh8000, 16'sh7fff, 16'sh0000, 16'shffff};
    run_plan();

    // Clip below and at a negative threshold; drive and mix past their range
    apply_settings(16'hfffc, 16'hff9c, 16'hffff, 16'hffff);
    plan = '{-16'sd101, -16'sd100, 16'sd100, 16'sh8000};
    run_plan();

    // Sine at full drive, half wet
    apply_settings({14'd0, MODE_SINE}, 16'h8000, GAIN_MAX, 16'd16384);
    plan = '{16'sh8000, 16'sh7fff, 16'sh0000, 16'sh0001};
    run_plan();

    // Tanh at full drive, fully wet
    apply_settings({14'h3fff, MODE_TANH}, 16'h7fff, GAIN_MAX, MIX_ONE);
    plan = '{16'sh8000, 16'sh7fff, 16'sh0000, 16'shffff};
    run_plan();

    // Cube at full drive; large inputs saturate
    apply_settings({14'd0, MODE_CUBE}, 16'h0000, GAIN_MAX, MIX_ONE);
    plan = '{16'sh8000, 16'sh7fff, 16'shffff, 16'sh4000};
    run_plan();

    // Lowest threshold never passes, zero drive, dry only
    apply_settings({14'd0, MODE_CLIP}, 16'h8000, 16'd0, 16'd0);
    plan = '{16'sh8000, 16'sh7fff};
    run_plan();

    // Random bursts: modes in rotation across four idling patterns
    for (int p = 0; p < 12; p++) begin
      case ((p / 3) % 4)
        0:       begin send_idle_pct = 0;  stall_pct = 0;  end
        1:       begin send_idle_pct = 67; stall_pct = 0;  end
        2:       begin send_idle_pct = 0;  stall_pct = 67; end
        default: begin send_idle_pct = 15; stall_pct = 15; end
      endcase
      mode_word      = 16'($urandom);
      mode_word[1:0] = 2'(p % 4);
      apply_settings(mode_word, pick_threshold(), pick_drive(), pick_mix());
      // fill the pipe against a held output once
      if (p == 1) holds_asked++;
      for (int k = 0; k < 31; k++) offer(random_sample(), $urandom_range(7) == 0);
      close_burst();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Checked %0d samples: clip %0d, sine %0d, tanh %0d, cube %0d",
             sb.checked, sb.per_mode[MODE_CLIP], sb.per_mode[MODE_SINE],
             sb.per_mode[MODE_TANH], sb.per_mode[MODE_CUBE]);
    $display("%0d register writes, idle and stall patterns, one long output hold",
             reg_writes);
    if (sb.mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
